// File: src/ldpc_cn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ldpc_cn_pkg;

   // LLR arithmetic
   localparam int LLR_W = 16;
   localparam int MAG_W = LLR_W - 1;
   localparam int SUM_W = LLR_W + 1;
   localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

   // Row geometry
   localparam int MAX_DEGREE = 32;
   localparam int IDX_W = $clog2(MAX_DEGREE);
   localparam int CNT_W = $clog2(MAX_DEGREE + 1);

   // Row descriptor queue; one row buffer bank per queue slot
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int BANK_W = QPTR_W;
   localparam int ADDR_W = BANK_W + IDX_W;

   // Configuration registers
   localparam int NORM_W = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 15;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORM_EIGHTHS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_OFFSET = 1'b1;
   localparam logic [NORM_W-1:0] NORM_RESET = 4'd8;

   typedef logic signed [LLR_W-1:0] llr_type;
   typedef logic [MAG_W-1:0] mag_type;

   typedef struct packed {
      logic [NORM_W-1:0] norm_eighths;
      mag_type min_offset;
   } cfg_type;

   // Everything the back end needs to emit one row
   typedef struct packed {
      logic [BANK_W-1:0] bank;
      logic [CNT_W-1:0] count;
      mag_type first_min;
      mag_type second_min;
      logic parity;
   } row_desc_type;

   // Row buffer write port
   typedef struct packed {
      logic en;
      logic [ADDR_W-1:0] addr;
      llr_type data;
   } mem_wr_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_OFFSET,
      BACK_SCALE,
      BACK_RUN
   } back_state_type;

   // Saturate a grown sum to +-(2^(LLR_W-1) - 1)
   function automatic llr_type sat_llr(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      llr_type r;
      hi = SUM_W'(signed'({1'b0, MAG_MAX}));
      lo = -hi;
      if (v > hi) begin
         r = LLR_W'(hi);
      end else if (v < lo) begin
         r = LLR_W'(lo);
      end else begin
         r = v[LLR_W-1:0];
      end
      return r;
   endfunction

   // Magnitude of a saturated LLR (never the most negative code)
   function automatic mag_type abs_llr(input llr_type v);
      llr_type n;
      n = -v;
      return v[LLR_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: src/ldpc_cn_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ldpc_cn_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire ldpc_cn_pkg::row_desc_type push_desc,
   output      logic                      full,
   input  wire logic                      pop,
   output      ldpc_cn_pkg::row_desc_type head_desc,
   output      logic                      empty
);
   import ldpc_cn_pkg::*;

   row_desc_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_desc = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // descriptor slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

// File: src/ldpc_cn_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ldpc_cn_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   output      logic                      req_full,
   input  wire ldpc_cn_pkg::llr_type      req_posterior,
   input  wire ldpc_cn_pkg::llr_type      req_old_message,
   input  wire logic                      req_last_edge,
   output      ldpc_cn_pkg::mem_wr_type   mem_wr,
   output      logic                      desc_push,
   output      ldpc_cn_pkg::row_desc_type desc,
   input  wire logic                      desc_full
);
   import ldpc_cn_pkg::*;

   logic [CNT_W-1:0]  count_ff, count_in;
   mag_type           first_ff, first_in;
   mag_type           second_ff, second_in;
   logic              parity_ff, parity_in;
   logic [BANK_W-1:0] bank_ff, bank_in;

   logic                    accept, room, store;
   logic signed [SUM_W-1:0] diff;
   llr_type                 contrib;
   mag_type                 mag, larger;
   logic [CNT_W-1:0]        count_upd;
   mag_type                 first_upd, second_upd;
   logic                    parity_upd;

   // the bank being filled is held until the back end drains it
   assign req_full = desc_full;
   assign accept   = req_push && !req_full;
   assign room     = (count_ff != CNT_W'(MAX_DEGREE));
   assign store    = accept && room;

   // contribution = posterior - old message, saturated
   assign diff    = SUM_W'(req_posterior) - SUM_W'(req_old_message);
   assign contrib = sat_llr(diff);
   assign mag     = abs_llr(contrib);
   assign larger  = (mag > first_ff) ? mag : first_ff;

   // row statistics including this edge (unchanged when the row is full)
   always_comb begin
      count_upd  = count_ff;
      first_upd  = first_ff;
      second_upd = second_ff;
      parity_upd = parity_ff;
      if (room) begin
         count_upd  = count_ff + 1'b1;
         first_upd  = (mag < first_ff) ? mag : first_ff;
         second_upd = (larger < second_ff) ? larger : second_ff;
         parity_upd = parity_ff ^ contrib[LLR_W-1];
      end
   end

   assign mem_wr.en   = store;
   assign mem_wr.addr = {bank_ff, count_ff[IDX_W-1:0]};
   assign mem_wr.data = contrib;

   assign desc_push       = accept && req_last_edge;
   assign desc.bank       = bank_ff;
   assign desc.count      = count_upd;
   assign desc.first_min  = first_upd;
   assign desc.second_min = second_upd;
   assign desc.parity     = parity_upd;

   // row accumulation; a row close clears it and moves to the next bank
   always_comb begin
      count_in  = count_ff;
      first_in  = first_ff;
      second_in = second_ff;
      parity_in = parity_ff;
      bank_in   = bank_ff;
      if (desc_push) begin
         count_in  = '0;
         first_in  = MAG_MAX;
         second_in = MAG_MAX;
         parity_in = 1'b0;
         bank_in   = bank_ff + 1'b1;
      end else if (accept) begin
         count_in  = count_upd;
         first_in  = first_upd;
         second_in = second_upd;
         parity_in = parity_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         first_ff  <= MAG_MAX;
         second_ff <= MAG_MAX;
         parity_ff <= 1'b0;
         bank_ff   <= '0;
      end else begin
         count_ff  <= count_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         parity_ff <= parity_in;
         bank_ff   <= bank_in;
      end
   end

endmodule

`default_nettype wire

// File: src/ldpc_cn_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ldpc_cn_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ldpc_cn_pkg::cfg_type      cfg,
   input  wire ldpc_cn_pkg::mem_wr_type   mem_wr,
   input  wire ldpc_cn_pkg::row_desc_type desc,
   input  wire logic                      desc_empty,
   output      logic                      desc_pop,
   input  wire logic                      rsp_pop,
   output      logic                      rsp_empty,
   output      ldpc_cn_pkg::llr_type      rsp_new_message,
   output      ldpc_cn_pkg::llr_type      rsp_new_posterior,
   output      logic                      rsp_row_done
);
   import ldpc_cn_pkg::*;

   // row buffer, one bank per queued row
   llr_type store_ff [2**ADDR_W];

   back_state_type    state_ff, state_in;
   logic [BANK_W-1:0] bank_ff;
   logic [CNT_W-1:0]  count_ff;
   mag_type           first_ff, second_ff;
   logic              parity_ff;
   mag_type           d1_ff, d2_ff;
   mag_type           c1_ff, c2_ff;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              inflight_ff, inflight_in;
   logic              inflight_last_ff;
   llr_type           rd_data_ff;
   logic              out_valid_ff, out_valid_in;
   llr_type           out_msg_ff, out_post_ff;
   logic              out_done_ff;

   logic    latch_desc, issue, last_issue, slot_free;
   mag_type rd_mag, sel_mag;
   logic    msg_neg;
   llr_type msg;
   logic signed [SUM_W-1:0] post_sum;

   // offset subtraction with clamp at zero
   function automatic mag_type sub_offset(input mag_type m, input mag_type off);
      logic [MAG_W:0] d;
      d = {1'b0, m} - {1'b0, off};
      return d[MAG_W] ? '0 : d[MAG_W-1:0];
   endfunction

   // k/8 scaling by shift-add; 0 acts as 1, 8 and above as unity
   function automatic mag_type scale_eighths(input mag_type d, input logic [NORM_W-1:0] k);
      logic [NORM_W-1:0] kk;
      mag_type r;
      kk = (k == '0) ? NORM_W'(1) : k;
      if (kk[3]) begin
         r = d;
      end else begin
         r = (kk[2] ? (d >> 1) : '0) + (kk[1] ? (d >> 2) : '0) + (kk[0] ? (d >> 3) : '0);
      end
      return r;
   endfunction

   assign slot_free  = !out_valid_ff || rsp_pop;
   assign last_issue = (idx_ff + 1'b1 == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!desc_empty && !inflight_ff) begin
               state_in = BACK_OFFSET;
            end
         end
         BACK_OFFSET: state_in = BACK_SCALE;
         BACK_SCALE:  state_in = BACK_RUN;
         BACK_RUN: begin
            if (!inflight_ff && slot_free && last_issue) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      latch_desc = 1'b0;
      issue      = 1'b0;
      desc_pop   = 1'b0;
      unique case (state_ff)
         BACK_IDLE:   latch_desc = !desc_empty && !inflight_ff;
         BACK_OFFSET: ;
         BACK_SCALE:  ;
         BACK_RUN: begin
            issue    = !inflight_ff && slot_free;
            desc_pop = issue && last_issue;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // row setup: copy descriptor, then offset, then scale
   always_ff @(posedge clock) begin
      if (latch_desc) begin
         bank_ff   <= desc.bank;
         count_ff  <= desc.count;
         first_ff  <= desc.first_min;
         second_ff <= desc.second_min;
         parity_ff <= desc.parity;
      end
      if (state_ff == BACK_OFFSET) begin
         d1_ff <= sub_offset(second_ff, cfg.min_offset);
         d2_ff <= sub_offset(first_ff, cfg.min_offset);
      end
      if (state_ff == BACK_SCALE) begin
         c1_ff <= scale_eighths(d1_ff, cfg.norm_eighths);
         c2_ff <= scale_eighths(d2_ff, cfg.norm_eighths);
      end
   end

   // read index and in-flight tracking
   always_comb begin
      idx_in = idx_ff;
      if (state_ff == BACK_SCALE) begin
         idx_in = '0;
      end else if (issue) begin
         idx_in = idx_ff + 1'b1;
      end
      inflight_in  = issue;
      out_valid_in = inflight_ff ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         inflight_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         inflight_ff  <= inflight_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // row buffer write and registered read
   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         store_ff[mem_wr.addr] <= mem_wr.data;
      end
      if (issue) begin
         rd_data_ff       <= store_ff[{bank_ff, idx_ff[IDX_W-1:0]}];
         inflight_last_ff <= last_issue;
      end
   end

   // new message and posterior from the stored contribution
   assign rd_mag   = abs_llr(rd_data_ff);
   assign sel_mag  = (rd_mag == first_ff) ? c1_ff : c2_ff;
   assign msg_neg  = parity_ff ^ rd_data_ff[LLR_W-1];
   assign msg      = msg_neg ? -llr_type'({1'b0, sel_mag}) : llr_type'({1'b0, sel_mag});
   assign post_sum = SUM_W'(rd_data_ff) + SUM_W'(msg);

   always_ff @(posedge clock) begin
      if (inflight_ff) begin
         out_msg_ff  <= msg;
         out_post_ff <= sat_llr(post_sum);
         out_done_ff <= inflight_last_ff;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_new_message   = out_msg_ff;
   assign rsp_new_posterior = out_post_ff;
   assign rsp_row_done      = out_done_ff;

endmodule

`default_nettype wire

// File: src/ldpc_layered_min_sum_check_node_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Check-node unit for layered offset-normalized min-sum LDPC decoding. Push one
// edge per item (posterior, old message, last_edge on the row's final edge);
// after the last edge the block returns one result per stored edge in arrival
// order, row_done on the final one. Edges beyond 32 in a row are dropped. The
// front end takes one edge per clock while full is low, into one of two row
// buffer banks, so the next row loads while the previous one drains; full is
// high from the close of a second pending row until the back end issues the last
// row buffer read of the older one. Each row starts with setup (descriptor copy,
// offset, scale); then one row buffer read is in flight at a time, issued when
// the output slot is free or popped. The user must write configuration only
// while the block is idle, which it does not enforce; csr_ready is always high.
module ldpc_layered_min_sum_check_node_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   output      logic                                  req_full,
   input  wire ldpc_cn_pkg::llr_type                  req_posterior,
   input  wire ldpc_cn_pkg::llr_type                  req_old_message,
   input  wire logic                                  req_last_edge,
   output      logic                                  rsp_empty,
   input  wire logic                                  rsp_pop,
   output      ldpc_cn_pkg::llr_type                  rsp_new_message,
   output      ldpc_cn_pkg::llr_type                  rsp_new_posterior,
   output      logic                                  rsp_row_done,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [ldpc_cn_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ldpc_cn_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ldpc_cn_pkg::*;

   logic [NORM_W-1:0] norm_ff, norm_in;
   mag_type           offset_ff, offset_in;
   cfg_type           cfg;
   mem_wr_type        mem_wr;
   row_desc_type      push_desc, head_desc;
   logic              desc_push, desc_pop, desc_full, desc_empty;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      norm_in   = norm_ff;
      offset_in = offset_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NORM_EIGHTHS: norm_in   = csr_data[NORM_W-1:0];
            CSR_MIN_OFFSET:   offset_in = csr_data[MAG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff   <= NORM_RESET;
         offset_ff <= '0;
      end else begin
         norm_ff   <= norm_in;
         offset_ff <= offset_in;
      end
   end

   assign cfg.norm_eighths = norm_ff;
   assign cfg.min_offset   = offset_ff;

   ldpc_cn_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_posterior   (req_posterior),
      .req_old_message (req_old_message),
      .req_last_edge   (req_last_edge),
      .mem_wr          (mem_wr),
      .desc_push       (desc_push),
      .desc            (push_desc),
      .desc_full       (desc_full)
   );

   ldpc_cn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_desc (push_desc),
      .full      (desc_full),
      .pop       (desc_pop),
      .head_desc (head_desc),
      .empty     (desc_empty)
   );

   ldpc_cn_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .mem_wr            (mem_wr),
      .desc              (head_desc),
      .desc_empty        (desc_empty),
      .desc_pop          (desc_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_new_message   (rsp_new_message),
      .rsp_new_posterior (rsp_new_posterior),
      .rsp_row_done      (rsp_row_done)
   );

endmodule

`default_nettype wire

// File: src/ldpc_cn_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ldpc_cn_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_full,
   input wire logic                                rsp_empty,
   input wire logic                                rsp_pop,
   input wire ldpc_cn_pkg::llr_type                rsp_new_message,
   input wire ldpc_cn_pkg::llr_type                rsp_new_posterior,
   input wire logic                                rsp_row_done
);
   import ldpc_cn_pkg::*;

   // no result and both banks free right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> rsp_empty && !req_full)
      else $error("result pending or input blocked after reset");

   // a waiting result holds until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_new_message)
         && $stable(rsp_new_posterior) && $stable(rsp_row_done))
      else $error("result changed before transfer");

   // saturated outputs never reach the most negative code
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_new_message != {1'b1, {MAG_W{1'b0}}}
         && rsp_new_posterior != {1'b1, {MAG_W{1'b0}}})
      else $error("result outside the saturated LLR range");

   // results never come back to back
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop) |=> rsp_empty)
      else $error("result appeared back to back");

endmodule

bind ldpc_layered_min_sum_check_node_top ldpc_cn_checker u_checker (.*);

`default_nettype wire

// File: sim/ldpc_layered_min_sum_check_node_top_test.sv
`timescale 1ns / 1ps

module ldpc_layered_min_sum_check_node_top_test;

   import ldpc_cn_pkg::*;

   localparam int LLR_LIMIT = int'(MAG_MAX);
   localparam int EDGE_TARGET = 280;
   localparam int DRAIN_CYCLES = 16;
   localparam int LONG_HOLD = 300;

   // One expected edge update: new message, new posterior, end of row
   typedef struct {
      llr_type message;
      llr_type posterior;
      bit done;
   } edge_update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   llr_type req_posterior = '0;
   llr_type req_old_message = '0;
   logic req_last_edge = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   llr_type rsp_new_message;
   llr_type rsp_new_posterior;
   logic rsp_row_done;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Check row state tracked alongside the block
   int row_contrib[MAX_DEGREE];
   int row_edges = 0;
   int row_min1 = LLR_LIMIT;
   int row_min2 = LLR_LIMIT;
   bit row_parity = 1'b0;
   logic [NORM_W-1:0] norm_setting = NORM_RESET;
   int offset_setting = 0;

   edge_update_type pending_updates[$];
   edge_update_type oldest_update;
   int error_count = 0;
   int edges_sent = 0;
   bit idle_on = 1'b1;
   int rx_hold = 0;

   ldpc_layered_min_sum_check_node_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_posterior     (req_posterior),
      .req_old_message   (req_old_message),
      .req_last_edge     (req_last_edge),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_new_message   (rsp_new_message),
      .rsp_new_posterior (rsp_new_posterior),
      .rsp_row_done      (rsp_row_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #2 clock = ~clock;

   // Saturate to the symmetric LLR range
   function automatic int clip_llr(input int v);
      if (v > LLR_LIMIT) begin
         return LLR_LIMIT;
      end
      if (v < -LLR_LIMIT) begin
         return -LLR_LIMIT;
      end
      return v;
   endfunction

   // Offset, clamp at zero, then k/8 by shift-add
   function automatic int scale_magnitude(input int m);
      int d;
      int k;
      int r;
      d = m - offset_setting;
      k = int'(norm_setting);
      r = 0;
      if (d <= 0) begin
         return 0;
      end
      if (k == 0) begin
         k = 1;
      end
      if (k >= 8) begin
         return d;
      end
      if (k[2]) r += d >>> 1;
      if (k[1]) r += d >>> 2;
      if (k[0]) r += d >>> 3;
      return r;
   endfunction

   // Fold one accepted edge into the row; on the last edge queue the updates
   task automatic update_check_row(input llr_type posterior, input llr_type old_message,
                                   input bit last_edge);
      int c;
      int a;
      int prev;
      int mx;
      int mag_ext;
      int mag_min;
      int msg;
      bit s;
      edge_update_type upd;
      if (row_edges < MAX_DEGREE) begin
         c = clip_llr(int'(posterior) - int'(old_message));
         a = (c < 0) ? -c : c;
         prev = row_min1;
         row_contrib[row_edges] = c;
         row_edges++;
         if (c < 0) row_parity = ~row_parity;
         if (a < row_min1) row_min1 = a;
         mx = (a > prev) ? a : prev;
         if (mx < row_min2) row_min2 = mx;
      end
      if (last_edge) begin
         mag_ext = scale_magnitude(row_min2);
         mag_min = scale_magnitude(row_min1);
         for (int i = 0; i < row_edges; i++) begin
            c = row_contrib[i];
            a = (c < 0) ? -c : c;
            s = row_parity ^ (c < 0);
            msg = (a == row_min1) ? mag_ext : mag_min;
            if (s) msg = -msg;
            upd.message = llr_type'(msg);
            upd.posterior = llr_type'(clip_llr(c + msg));
            upd.done = (i == row_edges - 1);
            pending_updates.push_back(upd);
         end
         row_edges = 0;
         row_min1 = LLR_LIMIT;
         row_min2 = LLR_LIMIT;
         row_parity = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   // Compare each popped result with the oldest expected update
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_updates.size() == 0) begin
            report_mismatch("result with nothing pending", int'(rsp_new_message), 0);
         end else begin
            oldest_update = pending_updates.pop_front();
            if (rsp_new_message !== oldest_update.message)
               report_mismatch("new_message", int'(rsp_new_message),
                               int'(oldest_update.message));
            if (rsp_new_posterior !== oldest_update.posterior)
               report_mismatch("new_posterior", int'(rsp_new_posterior),
                               int'(oldest_update.posterior));
            if (rsp_row_done !== oldest_update.done)
               report_mismatch("row_done", int'(rsp_row_done), int'(oldest_update.done));
         end
      end
   end

   // Result side: random stall bursts, plus long holds on request
   initial begin
      int rx_stall;
      rx_stall = 0;
      forever begin
         @(negedge clock);
         if (rx_hold > 0) begin
            rsp_pop <= 1'b0;
            rx_hold--;
         end else if (rx_stall > 0) begin
            rsp_pop <= 1'b0;
            rx_stall--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_pop <= 1'b0;
            rx_stall = $urandom_range(1, 19) - 1;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Offer one edge, hold it until the transfer, leave push high for the next one
   task automatic send_edge(input llr_type posterior, input llr_type old_message,
                            input bit last_edge);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_posterior <= posterior;
      req_old_message <= old_message;
      req_last_edge <= last_edge;
      do @(posedge clock); while (req_full);
      update_check_row(posterior, old_message, last_edge);
      edges_sent++;
      @(negedge clock);
   endtask

   function automatic llr_type random_llr(input int mode);
      int v;
      case (mode)
         0: v = int'($urandom_range(0, 65534)) - LLR_LIMIT;
         1: v = int'($urandom_range(0, 80)) - 40;
         default: v = $urandom_range(0, 1) ? LLR_LIMIT - int'($urandom_range(0, 3))
                                           : -LLR_LIMIT + int'($urandom_range(0, 3));
      endcase
      return llr_type'(v);
   endfunction

   task automatic send_random_row(input int len, input int mode);
      for (int i = 0; i < len; i++) begin
         send_edge(random_llr(mode), random_llr(mode), i == len - 1);
      end
   endtask

   // Stop offering, let every expected result drain, then allow the pipeline to settle
   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input int value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_NORM_EIGHTHS) begin
         norm_setting = NORM_W'(value);
      end else begin
         offset_setting = int'(mag_type'(value));
      end
      @(negedge clock);
   endtask

   task automatic configure(input int norm, input int offset);
      wait_idle();
      write_csr(CSR_NORM_EIGHTHS, norm);
      write_csr(CSR_MIN_OFFSET, offset);
      csr_valid <= 1'b0;
   endtask

   // Rows of one edge, each closed by its only edge
   task automatic test_single_edge_rows();
      send_edge(16'sd32767, -16'sd32767, 1'b1);
      send_edge(-16'sd32767, 16'sd32767, 1'b1);
      send_edge(16'sd0, 16'sd0, 1'b1);
   endtask

   // Contributions and posteriors that hit both rails
   task automatic test_saturation();
      send_edge(16'sd32767, -16'sd32767, 1'b0);
      send_edge(-16'sd32767, 16'sd32767, 1'b0);
      send_edge(16'sd32767, 16'sd32767, 1'b0);
      send_edge(-16'sd1, 16'sd32767, 1'b1);
   endtask

   // Equal smallest magnitudes, and a zero contribution as the minimum
   task automatic test_ties_and_zero();
      send_edge(16'sd7, 16'sd0, 1'b0);
      send_edge(16'sd10, 16'sd7, 1'b0);
      send_edge(-16'sd3, 16'sd0, 1'b0);
      send_edge(16'sd12, 16'sd0, 1'b0);
      send_edge(16'sd0, 16'sd7, 1'b1);
      send_edge(16'sd5, 16'sd5, 1'b0);
      send_edge(-16'sd4, 16'sd0, 1'b0);
      send_edge(16'sd20, 16'sd11, 1'b1);
   endtask

   // Scale factors in and out of range, offsets up to the full magnitude
   task automatic test_scale_and_offset();
      int norms[5] = '{0, 7, 15, 5, 1};
      int offsets[5] = '{0, 100, 32767, 3, 0};
      for (int i = 0; i < 5; i++) begin
         configure(norms[i], offsets[i]);
         send_edge(llr_type'(1000 + 37 * i), -16'sd234, 1'b0);
         send_edge(-16'sd513, llr_type'(77 + i), 1'b1);
      end
      configure(8, 0);
   endtask

   // Rows longer than the row buffer, and one that just fits: surplus edges are dropped
   task automatic test_row_overflow();
      send_random_row(36, 0);
      send_random_row(MAX_DEGREE + 1, 1);
      send_random_row(MAX_DEGREE, 0);
   endtask

   // Receiver holds off while rows keep coming, so both banks fill and push stalls
   task automatic test_backpressure();
      wait_idle();
      @(posedge clock);
      rx_hold = LONG_HOLD;
      @(negedge clock);
      for (int r = 0; r < 4; r++) begin
         send_random_row(6, $urandom_range(0, 2));
      end
   endtask

   // Random settings and rows; mostly short rows, now and then a long one
   task automatic test_random_rows();
      int len;
      int sel;
      while (edges_sent < EDGE_TARGET) begin
         if (edges_sent >= EDGE_TARGET - 40 && idle_on) begin
            wait_idle();
            @(posedge clock);
            idle_on = 1'b0;
            @(negedge clock);
         end
         configure($urandom_range(0, 15),
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
                                             : $urandom_range(0, 64));
         for (int r = 0; r < 4; r++) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) len = $urandom_range(1, 6);
            else if (sel < 9) len = $urandom_range(7, 16);
            else len = $urandom_range(17, MAX_DEGREE);
            send_random_row(len, $urandom_range(0, 2));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_single_edge_rows();
      test_saturation();
      test_ties_and_zero();
      test_scale_and_offset();
      test_row_overflow();
      test_backpressure();
      test_random_rows();
      wait_idle();
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
